// ----- rtl/lpr_pkg.sv -----
package lpr_pkg;

  // Table sizing
  localparam int MAX_ROUTES = 32;
  localparam int NUM_IFACES = 8;

  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 6;
  localparam int IFACE_W = 3;
  localparam int TTL_W   = 8;
  localparam int STAT_W  = 3;

  localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W = $clog2(MAX_ROUTES + 1);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ADDR_W);
  localparam int IFACE_TOP = (NUM_IFACES > (1 << IFACE_W)) ? ((1 << IFACE_W) - 1)
                                                           : (NUM_IFACES - 1);

  // Operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_ROUTE = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_FORWARDED = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROP_TTL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_ROUTE  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic               operation;
    logic [ADDR_W-1:0]  prefix;
    logic [LEN_W-1:0]   prefix_len;
    logic               has_next_hop;
    logic [ADDR_W-1:0]  gateway_addr;
    logic [IFACE_W-1:0] iface_index;
    logic [ADDR_W-1:0]  dst_addr;
    logic [TTL_W-1:0]   ttl_in;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IFACE_W-1:0] out_iface;
    logic [ADDR_W-1:0]  next_hop_addr;
    logic [TTL_W-1:0]   ttl_out;
  } rsp_t;

  // One stored route as it sits in the table RAM
  typedef struct packed {
    logic [ADDR_W-1:0]  prefix;
    logic [LEN_W-1:0]   len;
    logic               has_gw;
    logic [ADDR_W-1:0]  gw;
    logic [IFACE_W-1:0] iface;
  } route_t;

  localparam int ROUTE_W = $bits(route_t);

endpackage

// ----- rtl/lpr_ram.sv -----
module lpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lpr_match.sv -----
module lpr_match (
  input  lpr_pkg::route_t                entry,
  input  logic [lpr_pkg::ADDR_W-1:0]     dst,
  input  logic [lpr_pkg::LEN_W-1:0]      best_len,
  output logic                           hit
);
  import lpr_pkg::*;

  logic [ADDR_W-1:0] mask;

  // Stored lengths are at most 32; a shift by 32 clears the word
  assign mask = ~({ADDR_W{1'b1}} >> entry.len);
  assign hit  = (((entry.prefix ^ dst) & mask) == '0) && (entry.len >= best_len);

endmodule

// ----- rtl/ipv4_longest_prefix_router.sv -----
// Channel | Signals                   | Beat
// --------+---------------------------+--------------------------------------
// req     | req_valid, req_ready, req | add a route or route one header
// rsp     | rsp_valid, rsp_ready, rsp | status, interface, next hop, TTL
//
// An add, a dropped header or an empty-table lookup skips the scan: S_IDLE to S_DONE.
// A lookup walks every stored route through S_SCAN, then S_FIN, then S_DONE:
// the table RAM yields one route a cycle into a single masked compare unit.
// req_ready rises at the same clock edge that loads the result into rsp.
// Reset empties the table at once (the route count goes to zero); no sweep.
// req_ready is low while an item is in work; a result held by a stalled rsp
// beat lets the next item enter and work until its own result is ready.
module ipv4_longest_prefix_router (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  lpr_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output lpr_pkg::rsp_t  rsp
);
  import lpr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  rd_idx, rd_idx_next;
  logic              cmp_vld;

  logic [ADDR_W-1:0] dst;
  logic [TTL_W-1:0]  ttl_m1;
  logic [STAT_W-1:0] res_status, res_status_next;

  logic               found;
  logic [LEN_W-1:0]   best_len;
  logic               best_has_gw;
  logic [ADDR_W-1:0]  best_gw;
  logic [IFACE_W-1:0] best_iface;

  logic   accept;
  logic   rsp_free;
  logic   load_rsp;
  logic   start_scan;
  logic   hit;
  logic   take_hit;
  logic   ram_we;
  route_t wr_entry;
  route_t rd_entry;
  rsp_t   rsp_next;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign take_hit  = cmp_vld && hit;

  // Build the stored route: saturate length and interface, drop unused gateway
  always_comb begin
    wr_entry.prefix = req.prefix;
    wr_entry.len    = (req.prefix_len > LEN_MAX) ? LEN_MAX : req.prefix_len;
    wr_entry.has_gw = req.has_next_hop;
    wr_entry.gw     = req.has_next_hop ? req.gateway_addr : '0;
    wr_entry.iface  = (req.iface_index > IFACE_W'(IFACE_TOP)) ? IFACE_W'(IFACE_TOP)
                                                              : req.iface_index;
  end

  lpr_ram #(
    .WIDTH (ROUTE_W),
    .DEPTH (MAX_ROUTES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (rd_idx),
    .rdata (rd_entry)
  );

  // Shared compare unit: one stored route per cycle
  lpr_match u_match (
    .entry    (rd_entry),
    .dst      (dst),
    .best_len (best_len),
    .hit      (hit)
  );

  // Sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_idx_next     = rd_idx;
    res_status_next = res_status;
    ram_we          = 1'b0;
    start_scan      = 1'b0;
    load_rsp        = 1'b0;
    unique case (state)
      S_IDLE: begin
        rd_idx_next = '0;
        if (accept) begin
          priority if (req.operation == OP_ADD) begin
            state_next = S_DONE;
            if (count == CNT_W'(MAX_ROUTES)) begin
              res_status_next = ST_FULL;
            end else begin
              ram_we          = 1'b1;
              count_next      = count + CNT_W'(1);
              res_status_next = ST_ADDED;
            end
          end else if (req.ttl_in <= TTL_W'(1)) begin
            res_status_next = ST_DROP_TTL;
            state_next      = S_DONE;
          end else if (count == '0) begin
            res_status_next = ST_NO_ROUTE;
            state_next      = S_DONE;
          end else begin
            start_scan = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Advance the read pointer; the last issued read is compared in S_FIN
        rd_idx_next = rd_idx + IDX_W'(1);
        if (CNT_W'(rd_idx) + CNT_W'(1) == count) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        res_status_next = (found || take_hit) ? ST_FORWARDED : ST_NO_ROUTE;
        state_next      = S_DONE;
      end
      S_DONE: begin
        // Hold the result until the output register is free
        if (rsp_free) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_next        = '0;
    rsp_next.status = res_status;
    if (res_status == ST_FORWARDED) begin
      rsp_next.out_iface     = best_iface;
      rsp_next.next_hop_addr = best_has_gw ? best_gw : dst;
      rsp_next.ttl_out       = ttl_m1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_vld   <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      cmp_vld <= (state == S_SCAN);
      if (start_scan) begin
        found <= 1'b0;
      end else if (take_hit) begin
        found <= 1'b1;
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    rd_idx     <= rd_idx_next;
    res_status <= res_status_next;
    if (accept) begin
      dst    <= req.dst_addr;
      ttl_m1 <= req.ttl_in - TTL_W'(1);
    end
    if (start_scan) begin
      best_len <= '0;
    end else if (take_hit) begin
      // Equal length keeps the later route: compare is >=
      best_len    <= rd_entry.len;
      best_has_gw <= rd_entry.has_gw;
      best_gw     <= rd_entry.gw;
      best_iface  <= rd_entry.iface;
    end
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- dv/tb_ipv4_longest_prefix_router.sv -----
module tb_ipv4_longest_prefix_router;
  import lpr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 650;
  localparam int MAX_WAIT     = 12;
  localparam int DRAIN_CYCLES = 60;

  // Route table mirror plus the queue of results still owed by the block.
  class route_scoreboard;
    logic [ADDR_W-1:0]  rt_prefix [MAX_ROUTES];
    logic [LEN_W-1:0]   rt_len    [MAX_ROUTES];
    logic               rt_has_gw [MAX_ROUTES];
    logic [ADDR_W-1:0]  rt_gw     [MAX_ROUTES];
    logic [IFACE_W-1:0] rt_iface  [MAX_ROUTES];
    int                 route_count;
    rsp_t               owed_rsp [$];
    int                 mismatches;

    function new();
      route_count = 0;
      mismatches  = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t %s", $time, msg);
    endfunction

    // Update the mirrored table and queue the result this request must give.
    function void note_request(req_t r);
      rsp_t              want;
      logic [ADDR_W-1:0] mask;
      int                best;
      want = '0;
      best = -1;
      if (r.operation == OP_ADD) begin
        if (route_count >= MAX_ROUTES) begin
          want.status = ST_FULL;
        end else begin
          rt_prefix[route_count] = r.prefix;
          rt_len[route_count]    = (r.prefix_len > LEN_MAX) ? LEN_MAX : r.prefix_len;
          rt_has_gw[route_count] = r.has_next_hop;
          rt_gw[route_count]     = r.has_next_hop ? r.gateway_addr : '0;
          rt_iface[route_count]  = (r.iface_index > IFACE_W'(IFACE_TOP)) ? IFACE_W'(IFACE_TOP)
                                                                         : r.iface_index;
          route_count++;
          want.status = ST_ADDED;
        end
      end else if (r.ttl_in <= 1) begin
        want.status = ST_DROP_TTL;
      end else begin
        // Scan in insertion order; >= lets a later route of equal length win.
        for (int i = 0; i < route_count; i++) begin
          mask = ~({ADDR_W{1'b1}} >> rt_len[i]);
          if (((rt_prefix[i] ^ r.dst_addr) & mask) == '0 &&
              (best < 0 || rt_len[i] >= rt_len[best])) begin
            best = i;
          end
        end
        if (best < 0) begin
          want.status = ST_NO_ROUTE;
        end else begin
          want.status        = ST_FORWARDED;
          want.out_iface     = rt_iface[best];
          want.next_hop_addr = rt_has_gw[best] ? rt_gw[best] : r.dst_addr;
          want.ttl_out       = r.ttl_in - TTL_W'(1);
        end
      end
      owed_rsp = {owed_rsp, want};
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (owed_rsp.size() == 0) begin
        flag($sformatf("unexpected result beat: st=%0d if=%0d hop=%h ttl=%0d",
                       got.status, got.out_iface, got.next_hop_addr, got.ttl_out));
        return;
      end
      want = owed_rsp.pop_front();
      if (got.status !== want.status || got.out_iface !== want.out_iface ||
          got.next_hop_addr !== want.next_hop_addr || got.ttl_out !== want.ttl_out) begin
        flag($sformatf({"result mismatch: want st=%0d if=%0d hop=%h ttl=%0d,",
                        " got st=%0d if=%0d hop=%h ttl=%0d"},
                       want.status, want.out_iface, want.next_hop_addr, want.ttl_out,
                       got.status, got.out_iface, got.next_hop_addr, got.ttl_out));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  route_scoreboard board = new();

  // Quiet-stretch counters: while nonzero, that side never idles.
  int tx_calm = 0;
  int rx_calm = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  ipv4_longest_prefix_router dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Bail out if the run hangs; a missing beat would otherwise stall forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Draw an idle count for one beat; now and then open a stretch with none.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 30);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Present one request beat, hold it until accepted, then log it.
  // Entered and left at a falling edge, so valid is never dropped between
  // back-to-back beats.
  task automatic send_beat(req_t item);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       = item;
    req_valid = 1'b1;
    do @(posedge clk); while (req_ready !== 1'b1);
    board.note_request(item);
    @(negedge clk);
  endtask

  // Add a route; fill the lookup fields with noise the block must ignore.
  task automatic send_add(logic [ADDR_W-1:0] pfx, logic [LEN_W-1:0] len, logic has_gw,
                          logic [ADDR_W-1:0] gw, logic [IFACE_W-1:0] ifc);
    req_t item;
    item.operation    = OP_ADD;
    item.prefix       = pfx;
    item.prefix_len   = len;
    item.has_next_hop = has_gw;
    item.gateway_addr = gw;
    item.iface_index  = ifc;
    item.dst_addr     = $urandom;
    item.ttl_in       = TTL_W'($urandom_range(0, 255));
    send_beat(item);
  endtask

  // Route one header; fill the add fields with noise.
  task automatic send_lookup(logic [ADDR_W-1:0] dst, logic [TTL_W-1:0] ttl);
    req_t item;
    item.operation    = OP_ROUTE;
    item.prefix       = $urandom;
    item.prefix_len   = LEN_W'($urandom_range(0, 63));
    item.has_next_hop = 1'($urandom_range(0, 1));
    item.gateway_addr = $urandom;
    item.iface_index  = IFACE_W'($urandom_range(0, 7));
    item.dst_addr     = dst;
    item.ttl_in       = ttl;
    send_beat(item);
  endtask

  // Random add: lengths lean toward real ones, with some above 32 and some
  // prefixes reused from stored routes to build nesting and equal-length ties.
  task automatic random_add();
    logic [ADDR_W-1:0] pfx;
    logic [LEN_W-1:0]  len;
    int                pick;
    int                sel;
    sel = $urandom_range(0, 19);
    if (sel == 0)      len = '0;
    else if (sel == 1) len = LEN_W'($urandom_range(33, 63));
    else if (sel < 5)  len = LEN_MAX;
    else               len = LEN_W'($urandom_range(1, 31));
    pfx = $urandom;
    if (board.route_count > 0 && $urandom_range(0, 2) == 0) begin
      pick = $urandom_range(0, board.route_count - 1);
      pfx  = board.rt_prefix[pick];
      if ($urandom_range(0, 1) == 0) len = board.rt_len[pick];
    end
    send_add(pfx, len, 1'($urandom_range(0, 1)), $urandom,
             IFACE_W'($urandom_range(0, 7)));
  endtask

  // Random lookup: mostly aim inside a stored prefix, randomizing the host bits.
  task automatic random_lookup();
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] mask;
    logic [TTL_W-1:0]  ttl;
    int                pick;
    int                sel;
    dst = $urandom;
    if (board.route_count > 0 && $urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, board.route_count - 1);
      mask = ~({ADDR_W{1'b1}} >> board.rt_len[pick]);
      dst  = (board.rt_prefix[pick] & mask) | (dst & ~mask);
    end
    sel = $urandom_range(0, 15);
    if (sel == 0)      ttl = 8'd0;
    else if (sel == 1) ttl = 8'd1;
    else if (sel == 2) ttl = 8'd2;
    else if (sel == 3) ttl = 8'd255;
    else               ttl = TTL_W'($urandom_range(2, 255));
    send_lookup(dst, ttl);
  endtask

  // Result side: stall a random number of cycles, then take one beat.
  initial begin
    int stall;
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait(rx_calm);
      if (stall > 0) begin
        rsp_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      board.check_response(rsp);
      @(negedge clk);
    end
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty table: no route, plus the TTL drop edges and the lowest TTL that
    // still reaches the lookup.
    send_lookup(32'h0A00_0001, 8'd64);
    send_lookup(32'h0A00_0001, 8'd0);
    send_lookup(32'h0A00_0001, 8'd1);
    send_lookup(32'h0A00_0001, 8'd2);

    // Default route, nested prefixes, a direct route whose gateway field is
    // junk, over-long lengths that saturate, and an equal-length duplicate.
    send_add(32'h0000_0000, 6'd0,  1'b1, 32'hFFFF_FFFF, 3'd7);
    send_add(32'h0A00_0000, 6'd8,  1'b0, 32'hDEAD_BEEF, 3'd1);
    send_add(32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0001, 3'd2);
    send_add(32'h0A01_0203, 6'd32, 1'b0, 32'h1234_5678, 3'd3);
    send_add(32'hFFFF_FFFF, 6'd63, 1'b1, 32'h0102_0304, 3'd4);
    send_add(32'h0A01_0000, 6'd16, 1'b1, 32'hC0A8_0002, 3'd5);
    send_add(32'h0000_0000, 6'd40, 1'b1, 32'h0000_0000, 3'd6);
    send_add(32'h8000_0000, 6'd1,  1'b0, 32'h0000_0000, 3'd0);

    send_lookup(32'h0A01_0203, 8'd255);
    send_lookup(32'h0A01_0909, 8'd2);
    send_lookup(32'h0A09_0909, 8'd100);
    send_lookup(32'hFFFF_FFFF, 8'd3);
    send_lookup(32'h0000_0000, 8'd9);
    send_lookup(32'h7FFF_FFFF, 8'd50);
    send_lookup(32'h8000_0001, 8'd8);
    send_lookup(32'h0A01_0203, 8'd1);
    send_lookup(32'h0A01_0203, 8'd0);

    // Fill the table while routing, then keep routing with a few adds that
    // must bounce off the full table.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (board.route_count < MAX_ROUTES ? $urandom_range(0, 5) == 0
                                         : $urandom_range(0, 24) == 0) begin
        random_add();
      end else begin
        random_lookup();
      end
    end
    req_valid = 1'b0;

    // Drain owed results, then linger to catch any stray beat.
    while (board.owed_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
